FILE: hdl/rotate_vector_about_axis_macros.svh
// ----------------------------------------------------------------------------
// rotate_vector_about_axis_macros
// Assertion macros shared by the rotation block.
// ----------------------------------------------------------------------------
`ifndef ROTATE_VECTOR_ABOUT_AXIS_MACROS_SVH
`define ROTATE_VECTOR_ABOUT_AXIS_MACROS_SVH

// same-cycle implication, off during reset
`define RVA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define RVA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rva_pkg.sv
// ----------------------------------------------------------------------------
// rva_pkg
// Shared widths, constants and the arctangent table of the rotation block.
// ----------------------------------------------------------------------------
`default_nettype none

package rva_pkg;

	localparam int COORD_WIDTH_DEF   = 32;
	localparam int FRAC_BITS_DEF     = 16;
	localparam int CORDIC_STAGES_DEF = 24;

	localparam int ANGLE_WIDTH = 31;
	localparam int XW          = 34;   // CORDIC x/y, Q2.30 plus headroom
	localparam int ZW          = 34;   // CORDIC residual angle, Q2.30
	localparam int CS_W        = 33;   // sine / cosine
	localparam int OMC_W       = 34;   // one minus cosine
	localparam int MID_W       = 62;   // clamped product, +-2^60
	localparam int DOT_W       = 63;   // sum or difference of clamped products
	localparam int SUM_W       = 64;   // sum of three clamped products
	localparam int MUL_SPLIT   = 32;   // width of the low, unsigned half of operand a
	localparam int TRIG_SHIFT  = 30;

	localparam logic signed [XW-1:0]    CF_GAIN     = 34'sd652032874;
	localparam logic signed [ZW-1:0]    Q30_PI      = 34'sd3373259426;
	localparam logic signed [ZW-1:0]    Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [OMC_W-1:0] Q30_ONE     = 34'sd1073741824;

	localparam logic [31:0] ATAN_Q30 [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

endpackage

`default_nettype wire

FILE: hdl/rva_cordic_cell.sv
// ----------------------------------------------------------------------------
// rva_cordic_cell
// One rotation-mode CORDIC iteration; carries the item's side data along.
// ----------------------------------------------------------------------------
`default_nettype none

module rva_cordic_cell import rva_pkg::*; #(
	parameter int IDX = 0,
	parameter int SW  = 1
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [XW-1:0] x,
	input  logic signed [XW-1:0] y,
	input  logic signed [ZW-1:0] z,
	input  logic [SW-1:0]        side,
	output logic signed [XW-1:0] x_nxt,
	output logic signed [XW-1:0] y_nxt,
	output logic signed [ZW-1:0] z_nxt,
	output logic [SW-1:0]        side_nxt
);

	localparam logic signed [ZW-1:0] ATAN_I = ZW'(ATAN_Q30[IDX]);

	logic signed [XW-1:0] x_sh;
	logic signed [XW-1:0] y_sh;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic signed [ZW-1:0] z_q;
	logic [SW-1:0]        side_q;

	assign x_sh = x >>> IDX;
	assign y_sh = y >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (z >= 0) begin
				x_q <= x - y_sh;
				y_q <= y + x_sh;
				z_q <= z - ATAN_I;
			end else begin
				x_q <= x + y_sh;
				y_q <= y - x_sh;
				z_q <= z + ATAN_I;
			end
			side_q <= side;
		end
	end

	assign x_nxt    = x_q;
	assign y_nxt    = y_q;
	assign z_nxt    = z_q;
	assign side_nxt = side_q;

endmodule

`default_nettype wire

FILE: hdl/rva_mulsh.sv
// ----------------------------------------------------------------------------
// rva_mulsh
// Three-stage multiply, floor scale by SH and clamp to +-2^60.
// ----------------------------------------------------------------------------
`default_nettype none

module rva_mulsh import rva_pkg::*; #(
	parameter int AW = 32,
	parameter int BW = 32,
	parameter int SH = 16
) (
	input  logic                    clk,
	input  logic [2:0]              en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [MID_W-1:0] p,
	output logic                    clip
);

	localparam int AX  = (AW > MUL_SPLIT) ? AW : MUL_SPLIT + 1;
	localparam int HW  = AX - MUL_SPLIT;
	localparam int LW  = MUL_SPLIT + 1 + BW;
	localparam int PHW = HW + BW;
	localparam int FW  = AX + BW;
	localparam int EW  = ((FW > MID_W) ? FW : MID_W) + 1;
	localparam logic signed [EW-1:0] LIM_HI = EW'(64'sd1 <<< (MID_W - 2));
	localparam logic signed [EW-1:0] LIM_LO = -LIM_HI;

	logic signed [AX-1:0]    a_x;
	logic [MUL_SPLIT-1:0]    a_lo;
	logic signed [HW-1:0]    a_hi;
	logic signed [LW-1:0]    plo_s1;
	logic signed [PHW-1:0]   phi_s1;
	logic signed [FW-1:0]    full;
	logic signed [FW-1:0]    shd_s2;
	logic signed [EW-1:0]    shd_x;
	logic signed [MID_W-1:0] p_s3;
	logic                    clip_s3;

	assign a_x  = AX'(a);
	assign a_lo = a_x[MUL_SPLIT-1:0];
	assign a_hi = a_x[AX-1:MUL_SPLIT];

	// low half unsigned, high half signed
	assign full  = (FW'(phi_s1) <<< MUL_SPLIT) + FW'(plo_s1);
	assign shd_x = EW'(shd_s2);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			plo_s1 <= LW'($signed({1'b0, a_lo})) * LW'(b);
			phi_s1 <= PHW'(a_hi) * PHW'(b);
		end
		if (en[1]) begin
			shd_s2 <= full >>> SH;
		end
		if (en[2]) begin
			if (shd_x > LIM_HI) begin
				p_s3    <= MID_W'(LIM_HI);
				clip_s3 <= 1'b1;
			end else if (shd_x < LIM_LO) begin
				p_s3    <= MID_W'(LIM_LO);
				clip_s3 <= 1'b1;
			end else begin
				p_s3    <= MID_W'(shd_x);
				clip_s3 <= 1'b0;
			end
		end
	end

	assign p    = p_s3;
	assign clip = clip_s3;

endmodule

`default_nettype wire

FILE: hdl/rotate_vector_about_axis.sv
// Throughput: one item per cycle while rot_stall is low; every stage is a
// registered cell of the chain.
// Each stage advances when it is empty or its successor advances, so bubbles
// collapse and input is taken while a finished result waits.
// Reset (arst_n, asynchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// rotate_vector_about_axis
// Rodrigues rotation: v*cos + (k x v)*sin + k*(k.v)*(1-cos), Q16.16, CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotate_vector_about_axis_macros.svh"

module rotate_vector_about_axis import rva_pkg::*; #(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int FRAC_BITS     = FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic signed [COORD_WIDTH-1:0] axis_x,
	input  logic signed [COORD_WIDTH-1:0] axis_y,
	input  logic signed [COORD_WIDTH-1:0] axis_z,
	input  logic signed [COORD_WIDTH-1:0] vec_x,
	input  logic signed [COORD_WIDTH-1:0] vec_y,
	input  logic signed [COORD_WIDTH-1:0] vec_z,
	input  logic signed [ANGLE_WIDTH-1:0] turn_angle,
	output logic                          rot_valid,
	input  logic                          rot_stall,
	output logic signed [COORD_WIDTH-1:0] rot_x,
	output logic signed [COORD_WIDTH-1:0] rot_y,
	output logic signed [COORD_WIDTH-1:0] rot_z,
	output logic                          saturated
);

	localparam int W  = COORD_WIDTH;
	localparam int S  = CORDIC_STAGES;
	localparam int P  = S + 2;        // stage holding the CORDIC result
	localparam int N  = P + 12;       // output stage
	localparam int SW = 6 * W + 1;
	localparam logic signed [SUM_W-1:0] OUT_HI = (SUM_W'(1) <<< (W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] OUT_LO = -OUT_HI - SUM_W'(1);

	// ---------------- flow control ----------------
	logic [N:1]   valid_q;
	logic [N+1:1] en;

	assign en[N+1] = !rot_stall;
	for (genvar j = 1; j <= N; j++) begin : g_en
		assign en[j] = !valid_q[j] || en[j+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[1]) valid_q[1] <= item_valid;
			for (int j = 2; j <= N; j++) begin
				if (en[j]) valid_q[j] <= valid_q[j-1];
			end
		end
	end

	assign item_stall = !en[1];
	assign rot_valid  = valid_q[N];

	// ---------------- capture and angle fold ----------------
	logic signed [W-1:0]           k_s1 [3];
	logic signed [W-1:0]           v_s1 [3];
	logic signed [ANGLE_WIDTH-1:0] ang_s1;
	logic signed [ZW-1:0]          z_raw;
	logic signed [ZW-1:0]          z_fold;
	logic                          flip_fold;
	logic signed [XW-1:0]          x_s2;
	logic signed [XW-1:0]          y_s2;
	logic signed [ZW-1:0]          z_s2;
	logic [SW-1:0]                 side_s2;

	assign z_raw = ZW'(ang_s1) <<< 2;

	// beyond +-pi/2: shift by pi and negate sine and cosine
	always_comb begin
		z_fold    = z_raw;
		flip_fold = 1'b0;
		if (z_raw > Q30_HALF_PI) begin
			z_fold    = z_raw - Q30_PI;
			flip_fold = 1'b1;
		end else if (z_raw < -Q30_HALF_PI) begin
			z_fold    = z_raw + Q30_PI;
			flip_fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			k_s1[0] <= axis_x;
			k_s1[1] <= axis_y;
			k_s1[2] <= axis_z;
			v_s1[0] <= vec_x;
			v_s1[1] <= vec_y;
			v_s1[2] <= vec_z;
			ang_s1  <= turn_angle;
		end
		if (en[2]) begin
			x_s2    <= CF_GAIN;
			y_s2    <= '0;
			z_s2    <= z_fold;
			side_s2 <= {flip_fold, k_s1[0], k_s1[1], k_s1[2], v_s1[0], v_s1[1], v_s1[2]};
		end
	end

	// ---------------- CORDIC chain ----------------
	logic signed [XW-1:0] cx    [S+1];
	logic signed [XW-1:0] cy    [S+1];
	logic signed [ZW-1:0] cz    [S+1];
	logic [SW-1:0]        cside [S+1];

	assign cx[0]    = x_s2;
	assign cy[0]    = y_s2;
	assign cz[0]    = z_s2;
	assign cside[0] = side_s2;

	for (genvar i = 0; i < S; i++) begin : g_cell
		rva_cordic_cell #(
			.IDX (i),
			.SW  (SW)
		) u_cell (
			.clk      (clk),
			.en       (en[3+i]),
			.x        (cx[i]),
			.y        (cy[i]),
			.z        (cz[i]),
			.side     (cside[i]),
			.x_nxt    (cx[i+1]),
			.y_nxt    (cy[i+1]),
			.z_nxt    (cz[i+1]),
			.side_nxt (cside[i+1])
		);
	end

	// ---------------- product stages ----------------
	logic signed [W-1:0]     k_p [3];
	logic signed [W-1:0]     v_p [3];
	logic                    flip_p;
	logic signed [XW-1:0]    c_full;
	logic signed [XW-1:0]    s_full;

	assign flip_p = cside[S][SW-1];
	for (genvar c = 0; c < 3; c++) begin : g_unpack
		assign k_p[c] = cside[S][(6-c)*W-1 -: W];
		assign v_p[c] = cside[S][(3-c)*W-1 -: W];
	end

	assign c_full = flip_p ? -cx[S] : cx[S];
	assign s_full = flip_p ? -cy[S] : cy[S];

	logic signed [W-1:0]       k_s   [1:4][3];
	logic signed [W-1:0]       v_s   [1:7][3];
	logic signed [CS_W-1:0]    c_s   [1:7];
	logic signed [CS_W-1:0]    s_s   [1:7];
	logic signed [OMC_W-1:0]   omc_s [1:7];
	logic signed [DOT_W-1:0]   cr_s  [4:7][3];
	logic signed [DOT_W-1:0]   dot_s4;
	logic [11:4]               flag_s;
	logic signed [SUM_W-1:0]   t_s11 [3];
	logic signed [W-1:0]       rot_q [3];
	logic                      sat_q;

	logic signed [MID_W-1:0] kv_p [3];
	logic signed [MID_W-1:0] xa_p [3];
	logic signed [MID_W-1:0] xb_p [3];
	logic signed [MID_W-1:0] kd_p [3];
	logic signed [MID_W-1:0] vc_p [3];
	logic signed [MID_W-1:0] cs_p [3];
	logic signed [MID_W-1:0] ko_p [3];
	logic [2:0]              kv_clip;
	logic [2:0]              xa_clip;
	logic [2:0]              xb_clip;
	logic [2:0]              kd_clip;
	logic [2:0]              vc_clip;
	logic [2:0]              cs_clip;
	logic [2:0]              ko_clip;

	for (genvar c = 0; c < 3; c++) begin : g_mul
		// k.v terms and both halves of the cross product
		rva_mulsh #(.AW(W), .BW(W), .SH(FRAC_BITS)) u_kv (
			.clk (clk), .en (en[P+3:P+1]), .a (k_p[c]), .b (v_p[c]),
			.p (kv_p[c]), .clip (kv_clip[c])
		);
		rva_mulsh #(.AW(W), .BW(W), .SH(FRAC_BITS)) u_xa (
			.clk (clk), .en (en[P+3:P+1]), .a (k_p[(c+1)%3]), .b (v_p[(c+2)%3]),
			.p (xa_p[c]), .clip (xa_clip[c])
		);
		rva_mulsh #(.AW(W), .BW(W), .SH(FRAC_BITS)) u_xb (
			.clk (clk), .en (en[P+3:P+1]), .a (k_p[(c+2)%3]), .b (v_p[(c+1)%3]),
			.p (xb_p[c]), .clip (xb_clip[c])
		);
		rva_mulsh #(.AW(DOT_W), .BW(W), .SH(FRAC_BITS)) u_kd (
			.clk (clk), .en (en[P+7:P+5]), .a (dot_s4), .b (k_s[4][c]),
			.p (kd_p[c]), .clip (kd_clip[c])
		);
		rva_mulsh #(.AW(W), .BW(CS_W), .SH(TRIG_SHIFT)) u_vc (
			.clk (clk), .en (en[P+10:P+8]), .a (v_s[7][c]), .b (c_s[7]),
			.p (vc_p[c]), .clip (vc_clip[c])
		);
		rva_mulsh #(.AW(DOT_W), .BW(CS_W), .SH(TRIG_SHIFT)) u_cs (
			.clk (clk), .en (en[P+10:P+8]), .a (cr_s[7][c]), .b (s_s[7]),
			.p (cs_p[c]), .clip (cs_clip[c])
		);
		rva_mulsh #(.AW(MID_W), .BW(OMC_W), .SH(TRIG_SHIFT)) u_ko (
			.clk (clk), .en (en[P+10:P+8]), .a (kd_p[c]), .b (omc_s[7]),
			.p (ko_p[c]), .clip (ko_clip[c])
		);
	end

	always_ff @(posedge clk) begin
		if (en[P+1]) begin
			k_s[1]   <= k_p;
			v_s[1]   <= v_p;
			c_s[1]   <= CS_W'(c_full);
			s_s[1]   <= CS_W'(s_full);
			omc_s[1] <= Q30_ONE - c_full;
		end
		for (int o = 2; o <= 4; o++) begin
			if (en[P+o]) k_s[o] <= k_s[o-1];
		end
		for (int o = 2; o <= 7; o++) begin
			if (en[P+o]) begin
				v_s[o]   <= v_s[o-1];
				c_s[o]   <= c_s[o-1];
				s_s[o]   <= s_s[o-1];
				omc_s[o] <= omc_s[o-1];
			end
		end
		if (en[P+4]) begin
			dot_s4 <= DOT_W'(kv_p[0]) + DOT_W'(kv_p[1]) + DOT_W'(kv_p[2]);
			for (int c = 0; c < 3; c++) begin
				cr_s[4][c] <= DOT_W'(xa_p[c]) - DOT_W'(xb_p[c]);
			end
			flag_s[4] <= (|kv_clip) | (|xa_clip) | (|xb_clip);
		end
		for (int o = 5; o <= 7; o++) begin
			if (en[P+o]) begin
				cr_s[o]   <= cr_s[o-1];
				flag_s[o] <= flag_s[o-1];
			end
		end
		if (en[P+8]) flag_s[8] <= flag_s[7] | (|kd_clip);
		if (en[P+9]) flag_s[9] <= flag_s[8];
		if (en[P+10]) flag_s[10] <= flag_s[9];
		if (en[P+11]) begin
			for (int c = 0; c < 3; c++) begin
				t_s11[c] <= SUM_W'(vc_p[c]) + SUM_W'(cs_p[c]) + SUM_W'(ko_p[c]);
			end
			flag_s[11] <= flag_s[10] | (|vc_clip) | (|cs_clip) | (|ko_clip);
		end
		if (en[N]) begin
			sat_q <= flag_s[11]
				| (t_s11[0] > OUT_HI) | (t_s11[0] < OUT_LO)
				| (t_s11[1] > OUT_HI) | (t_s11[1] < OUT_LO)
				| (t_s11[2] > OUT_HI) | (t_s11[2] < OUT_LO);
			for (int c = 0; c < 3; c++) begin
				if (t_s11[c] > OUT_HI) begin
					rot_q[c] <= W'(OUT_HI);
				end else if (t_s11[c] < OUT_LO) begin
					rot_q[c] <= W'(OUT_LO);
				end else begin
					rot_q[c] <= W'(t_s11[c]);
				end
			end
		end
	end

	assign rot_x     = rot_q[0];
	assign rot_y     = rot_q[1];
	assign rot_z     = rot_q[2];
	assign saturated = sat_q;

	// ---------------- checks ----------------
	`RVA_ASSERT_IMP(a_stall_full, clk, arst_n, item_stall, &valid_q, "input stalled with a free stage")
	`RVA_ASSERT_NEXT(a_no_dup, clk, arst_n, rot_valid && !rot_stall && !valid_q[N-1], !rot_valid, "result repeated after hand-off")
	`RVA_ASSERT_NEXT(a_fill, clk, arst_n, valid_q[N-1] && !rot_valid, rot_valid, "item not moved into empty output")

endmodule

`default_nettype wire
